FILE: sv/byte_dictionary_encoder_assert.svh
// Assertion macros for the byte dictionary encoder checks.
`ifndef BYTE_DICTIONARY_ENCODER_ASSERT_SVH
`define BYTE_DICTIONARY_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define BDE_ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("bde check failed");

// Next-cycle implication, disabled in reset.
`define BDE_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("bde check failed");

// Implication that also holds during reset.
`define BDE_ASSERT_ALWAYS(lbl, clk, a, b) \
   lbl: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("bde check failed");

`endif

FILE: sv/bde_pkg.sv
// Shared types, constants and helpers of the byte dictionary encoder.
`default_nettype none
package bde_pkg;

   localparam int unsigned MAX_CHUNK_BYTES_DEF = 4096;
   // Stream total for the largest chunk (65536 bytes, 9-bit codes) fits here.
   localparam int unsigned TOT_W = 18;
   localparam int unsigned MAX_DISTINCT = 254;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_PULL = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       stored_raw;
   } rsp_type;

   typedef struct packed {
      logic             done;
      logic [3:0]       width;
      logic [TOT_W-1:0] total;
      logic             declined;
   } size_type;

   // 1 bit for n <= 2, else ceil(log2(n-1)) + 1.
   function automatic logic [3:0] code_width(input logic [7:0] n);
      logic [7:0] m;
      logic [3:0] k;
      m = n - 8'd1;
      k = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if ((9'd1 << i) < {1'b0, m}) k = k + 4'd1;
      end
      if (n <= 8'd2) return 4'd1;
      return k + 4'd1;
   endfunction

endpackage
`default_nettype wire

FILE: sv/bde_size.sv
// Chunk close: code width, projected stream size and decline decision.
`default_nettype none
module bde_size #(
   parameter int unsigned MAX_CHUNK_BYTES = bde_pkg::MAX_CHUNK_BYTES_DEF,
   localparam int unsigned LEN_W = $clog2(MAX_CHUNK_BYTES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [7:0]       distinct_n,
   input  wire logic [LEN_W-1:0] chunk_len,
   input  wire logic             too_many,
   output bde_pkg::size_type     size_out
);

   localparam int unsigned PW = LEN_W + 4;
   localparam int unsigned TW = bde_pkg::TOT_W;

   logic [2:0]    stg_ff;
   logic [3:0]    w_ff;
   logic [PW-1:0] prod_ff;
   logic [TW-1:0] tot_ff;
   logic          declined_in;
   logic [PW:0]   sum_in;
   bde_pkg::size_type res_ff;

   always_comb begin
      sum_in = (PW+1)'(1) + (PW+1)'(distinct_n) + (PW+1)'((prod_ff + PW'(7)) >> 3);
      declined_in = (chunk_len == '0) || too_many || (distinct_n == 8'd0) ||
                    ({tot_ff, 1'b0} >= (TW+1)'(chunk_len));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff      <= '0;
         res_ff.done <= 1'b0;
      end else begin
         stg_ff      <= {stg_ff[1:0], start};
         res_ff.done <= stg_ff[2];
      end
      if (start) w_ff <= bde_pkg::code_width(distinct_n);
      if (stg_ff[0]) prod_ff <= PW'(chunk_len) * PW'(w_ff);
      if (stg_ff[1]) tot_ff <= TW'(sum_in);
      if (stg_ff[2]) begin
         res_ff.width    <= w_ff;
         res_ff.total    <= tot_ff;
         res_ff.declined <= declined_in;
      end
   end

   assign size_out = res_ff;

endmodule
`default_nettype wire

FILE: sv/byte_dictionary_encoder.sv
// Load: one byte per cycle, memories written directly, no reads.
// Close: the size unit runs, then a pull that closed the chunk proceeds.
// Pull: header sent directly, dictionary byte after a dict read; a code byte
// is packed bitwise; each code: chunk_store read, code_table read, code load.
// Synchronous reset clears control state; memories hold undefined data.
`default_nettype none
module byte_dictionary_encoder #(
   parameter int unsigned MAX_CHUNK_BYTES = bde_pkg::MAX_CHUNK_BYTES_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire bde_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output bde_pkg::rsp_type     rsp_data
);

   localparam int unsigned LEN_W  = $clog2(MAX_CHUNK_BYTES + 1);
   localparam int unsigned ADDR_W = $clog2(MAX_CHUNK_BYTES);
   localparam int unsigned TW     = bde_pkg::TOT_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SIZE = 7'b0000010,
      S_PULL = 7'b0000100,
      S_DICT = 7'b0001000,
      S_BITS = 7'b0010000,
      S_RD1  = 7'b0100000,
      S_RD2  = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      PH_LOADING  = 3'b001,
      PH_EMITTING = 3'b010,
      PH_FINISHED = 3'b100
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       n_ff, n_in;
   logic             many_ff, many_in;
   logic [255:0]     valid_ff, valid_in;
   logic             pend_ff, pend_in;
   logic [3:0]       w_ff, w_in;
   logic [TW-1:0]    total_ff, total_in;
   logic             decl_ff, decl_in;
   logic [TW-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0] elem_ff, elem_in;
   logic [8:0]       code_ff, code_in;
   logic [3:0]       left_ff, left_in;
   logic [7:0]       acc_ff, acc_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bde_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0] chunk_mem [MAX_CHUNK_BYTES];
   logic [7:0] code_mem  [256];
   logic [7:0] dict_mem  [bde_pkg::MAX_DISTINCT];
   logic [7:0] chunk_rd_ff, code_rd_ff, dict_rd_ff;

   logic              cs_we, ct_we, dl_we, cs_re, ct_re, dl_re;
   logic [ADDR_W-1:0] cs_waddr;
   logic [7:0]        ld_byte, dl_waddr, dl_raddr;

   logic             size_start;
   bde_pkg::size_type size_res;

   logic accept, can_out, last_out;

   bde_size #(.MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)) u_size (
      .clock      (clock),
      .reset      (reset),
      .start      (size_start),
      .distinct_n (n_in),
      .chunk_len  (len_in),
      .too_many   (many_in),
      .size_out   (size_res)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign can_out   = !rsp_valid_ff || rsp_ready;
   assign last_out  = ((pos_ff + TW'(1)) >= total_ff);
   assign ld_byte   = req_data.data_byte;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      len_in       = len_ff;
      n_in         = n_ff;
      many_in      = many_ff;
      valid_in     = valid_ff;
      pend_in      = pend_ff;
      w_in         = w_ff;
      total_in     = total_ff;
      decl_in      = decl_ff;
      pos_in       = pos_ff;
      elem_in      = elem_ff;
      code_in      = code_ff;
      left_in      = left_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      size_start   = 1'b0;
      cs_we = 1'b0; ct_we = 1'b0; dl_we = 1'b0;
      cs_re = 1'b0; ct_re = 1'b0; dl_re = 1'b0;
      cs_waddr = ADDR_W'(len_ff);
      dl_waddr = n_ff;
      dl_raddr = 8'(pos_ff - TW'(1));

      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.kind == bde_pkg::KIND_LOAD) begin
               // a load after close starts a fresh chunk
               if (phase_ff != PH_LOADING) begin
                  len_in   = '0;
                  n_in     = 8'd0;
                  many_in  = 1'b0;
                  valid_in = '0;
                  phase_in = PH_LOADING;
               end
               cs_waddr = ADDR_W'(len_in);
               dl_waddr = n_in;
               if (len_in < LEN_W'(MAX_CHUNK_BYTES)) begin
                  cs_we  = 1'b1;
                  len_in = len_in + LEN_W'(1);
                  if (!many_in && !valid_in[ld_byte]) begin
                     if (n_in >= 8'(bde_pkg::MAX_DISTINCT)) begin
                        many_in = 1'b1;
                     end else begin
                        ct_we             = 1'b1;
                        dl_we             = 1'b1;
                        valid_in[ld_byte] = 1'b1;
                        n_in              = n_in + 8'd1;
                     end
                  end
               end
               if (req_data.last_byte) begin
                  size_start = 1'b1;
                  pend_in    = 1'b0;
                  state_in   = S_SIZE;
               end
            end else if (accept) begin
               if (phase_ff == PH_LOADING) begin
                  size_start = 1'b1;
                  pend_in    = 1'b1;
                  state_in   = S_SIZE;
               end else begin
                  state_in = S_PULL;
               end
            end
         end
         S_SIZE: begin
            if (size_res.done) begin
               w_in     = size_res.width;
               total_in = size_res.total;
               decl_in  = size_res.declined;
               phase_in = PH_EMITTING;
               pos_in   = '0;
               elem_in  = '0;
               left_in  = 4'd0;
               state_in = pend_ff ? S_PULL : S_IDLE;
            end
         end
         S_PULL: begin
            if (phase_ff == PH_FINISHED) begin
               state_in = S_IDLE;
            end else if (decl_ff) begin
               if (can_out) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{out_byte: 8'd0, out_last: 1'b1, stored_raw: 1'b1};
                  phase_in     = PH_FINISHED;
                  state_in     = S_IDLE;
               end
            end else if (pos_ff == '0) begin
               if (can_out) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{out_byte: n_ff, out_last: last_out, stored_raw: 1'b0};
                  pos_in       = pos_ff + TW'(1);
                  if (last_out) phase_in = PH_FINISHED;
                  state_in     = S_IDLE;
               end
            end else if (pos_ff <= TW'(n_ff)) begin
               dl_re    = 1'b1;
               state_in = S_DICT;
            end else begin
               cnt_in   = 4'd0;
               state_in = S_BITS;
            end
         end
         S_DICT: begin
            if (can_out) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{out_byte: dict_rd_ff, out_last: last_out, stored_raw: 1'b0};
               pos_in       = pos_ff + TW'(1);
               if (last_out) phase_in = PH_FINISHED;
               state_in     = S_IDLE;
            end
         end
         S_BITS: begin
            if (cnt_ff == 4'd8) begin
               if (can_out) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{out_byte: acc_ff, out_last: last_out, stored_raw: 1'b0};
                  pos_in       = pos_ff + TW'(1);
                  if (last_out) phase_in = PH_FINISHED;
                  state_in     = S_IDLE;
               end
            end else if (left_ff != 4'd0) begin
               acc_in  = {acc_ff[6:0], code_ff[left_ff - 4'd1]};
               left_in = left_ff - 4'd1;
               cnt_in  = cnt_ff + 4'd1;
            end else if (elem_ff >= len_ff) begin
               // past the last element: zero padding
               acc_in = {acc_ff[6:0], 1'b0};
               cnt_in = cnt_ff + 4'd1;
            end else begin
               cs_re    = 1'b1;
               elem_in  = elem_ff + LEN_W'(1);
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            ct_re    = 1'b1;
            state_in = S_RD2;
         end
         S_RD2: begin
            code_in  = {1'b0, code_rd_ff};
            left_in  = w_ff;
            state_in = S_BITS;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cs_we) chunk_mem[cs_waddr] <= ld_byte;
      if (cs_re) chunk_rd_ff <= chunk_mem[elem_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ct_we) code_mem[ld_byte] <= dl_waddr;
      if (ct_re) code_rd_ff <= code_mem[chunk_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (dl_we) dict_mem[dl_waddr] <= ld_byte;
      if (dl_re) dict_rd_ff <= dict_mem[dl_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_LOADING;
         len_ff       <= '0;
         n_ff         <= 8'd0;
         many_ff      <= 1'b0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         decl_ff      <= 1'b0;
         pos_ff       <= '0;
         elem_ff      <= '0;
         left_ff      <= 4'd0;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         n_ff         <= n_in;
         many_ff      <= many_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         decl_ff      <= decl_in;
         pos_ff       <= pos_in;
         elem_ff      <= elem_in;
         left_ff      <= left_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff     <= w_in;
      total_ff <= total_in;
      code_ff  <= code_in;
      acc_ff   <= acc_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: sv/bde_checker.sv
// Port-level checks for the byte dictionary encoder, bound to the top level.
`default_nettype none
`include "byte_dictionary_encoder_assert.svh"
module bde_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire bde_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire bde_pkg::rsp_type rsp_data
);

   logic load_acc;
   assign load_acc = req_valid && req_ready && (req_data.kind == bde_pkg::KIND_LOAD);

   `BDE_ASSERT_IMPLY(a_raw_last, clock, reset, rsp_valid && rsp_data.stored_raw, rsp_data.out_last)
   `BDE_ASSERT_IMPLY(a_raw_zero, clock, reset, rsp_valid && rsp_data.stored_raw, rsp_data.out_byte == 8'd0)
   `BDE_ASSERT_ALWAYS(a_rst_idle, clock, reset, !rsp_valid && req_ready)
   `BDE_ASSERT_NEXT(a_load_quiet, clock, reset, load_acc && !rsp_valid, !rsp_valid)
   `BDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind byte_dictionary_encoder bde_checker u_bde_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the byte dictionary encoder.
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam int CHUNK_MAX = bde_pkg::MAX_CHUNK_BYTES_DEF;
   localparam int DRAIN_CYCLES = 100;

   typedef enum logic [2:0] {
      PH_LOAD = 3'b001,
      PH_EMIT = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   typedef struct {
      bde_pkg::req_type r;
      bit               typed;
      bit               has;
      bde_pkg::rsp_type x;
   } row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   bde_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   bde_pkg::rsp_type rsp_data;

   byte_dictionary_encoder u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // encoder state mirror
   logic [7:0] chunk_mem [CHUNK_MAX];
   logic [7:0] code_of [256];
   bit         known [256];
   logic [7:0] dict [254];
   int         chunk_len;
   int         n_values;
   bit         overflowed;
   int         emit_pos;
   int         stream_len;
   bit         decline;
   phase_type  phase;

   bde_pkg::rsp_type expected_bytes [$];
   int               mismatches;
   int               items_sent;
   bit               quiet;
   row_type          rows [$];

   function automatic void clear_chunk();
      chunk_len = 0;
      foreach (known[i]) known[i] = 1'b0;
      n_values = 0;
      overflowed = 1'b0;
      emit_pos = 0;
      stream_len = 0;
      decline = 1'b0;
      phase = PH_LOAD;
   endfunction

   function automatic int bits_per_code();
      int k;
      k = 0;
      if (n_values <= 2) return 1;
      while (k < 16 && (1 << k) < n_values - 1) k++;
      return k + 1;
   endfunction

   function automatic void close_chunk();
      int w;
      w = bits_per_code();
      stream_len = 1 + n_values + (chunk_len * w + 7) / 8;
      decline = chunk_len == 0 || overflowed || n_values == 0 || stream_len * 2 >= chunk_len;
      emit_pos = 0;
      phase = PH_EMIT;
   endfunction

   function automatic logic [7:0] packed_codes(int idx);
      int w, g, elem, pos;
      logic [7:0] acc;
      logic [8:0] c;
      w = bits_per_code();
      acc = '0;
      for (int j = 0; j < 8; j++) begin
         g = idx * 8 + j;
         elem = g / w;
         pos = g % w;
         acc = acc << 1;
         if (elem < chunk_len) begin
            c = {1'b0, code_of[chunk_mem[elem]]};
            acc[0] = c[w - 1 - pos];
         end
      end
      return acc;
   endfunction

   function automatic void encode_step(input bde_pkg::req_type r, output bit has,
                                       output bde_pkg::rsp_type o);
      has = 1'b0;
      o = '0;
      if (r.kind == bde_pkg::KIND_LOAD) begin
         if (phase != PH_LOAD) clear_chunk();
         if (chunk_len < CHUNK_MAX) begin
            chunk_mem[chunk_len] = r.data_byte;
            chunk_len++;
            if (!overflowed && !known[r.data_byte]) begin
               if (n_values >= bde_pkg::MAX_DISTINCT) overflowed = 1'b1;
               else begin
                  code_of[r.data_byte] = 8'(n_values);
                  dict[n_values] = r.data_byte;
                  known[r.data_byte] = 1'b1;
                  n_values++;
               end
            end
         end
         if (r.last_byte) close_chunk();
         return;
      end
      if (phase == PH_LOAD) close_chunk();
      if (phase == PH_DONE) return;
      has = 1'b1;
      if (decline) begin
         o = '{out_byte: 8'h00, out_last: 1'b1, stored_raw: 1'b1};
         phase = PH_DONE;
         return;
      end
      if (emit_pos == 0) o.out_byte = 8'(n_values);
      else if (emit_pos <= n_values) o.out_byte = dict[emit_pos - 1];
      else o.out_byte = packed_codes(emit_pos - 1 - n_values);
      o.out_last = emit_pos + 1 >= stream_len;
      emit_pos++;
      if (emit_pos >= stream_len) phase = PH_DONE;
   endfunction

   task automatic send(input bde_pkg::req_type r, input bit typed, input bit t_has,
                       input bde_pkg::rsp_type t_rsp);
      bit has;
      bde_pkg::rsp_type o;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      encode_step(r, has, o);
      if (typed) begin
         has = t_has;
         o = t_rsp;
      end
      if (has) expected_bytes.push_back(o);
      items_sent++;
   endtask

   // drop valid and wait until every expected item is back
   task automatic hold_off();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (expected_bytes.size() == 0);
   endtask

   task automatic load(input logic [7:0] b, input bit last);
      send('{kind: bde_pkg::KIND_LOAD, data_byte: b, last_byte: last}, 1'b0, 1'b0, '0);
   endtask

   task automatic pull();
      send('{kind: bde_pkg::KIND_PULL, data_byte: 8'($urandom), last_byte: 1'($urandom)},
           1'b0, 1'b0, '0);
   endtask

   function automatic void add_row(bit kind, logic [7:0] b, bit last, bit typed, bit has,
                                   logic [7:0] ob, bit ol, bit raw);
      row_type t;
      t.r = '{kind: kind, data_byte: b, last_byte: last};
      t.typed = typed;
      t.has = has;
      t.x = '{out_byte: ob, out_last: ol, stored_raw: raw};
      rows.push_back(t);
   endfunction

   // receiver stalls
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %h/%b/%b",
               rsp_data.out_byte, rsp_data.out_last, rsp_data.stored_raw);
         end else begin
            bde_pkg::rsp_type e;
            e = expected_bytes.pop_front();
            if (rsp_data.out_byte !== e.out_byte || rsp_data.out_last !== e.out_last ||
                rsp_data.stored_raw !== e.stored_raw) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                  e.out_byte, e.out_last, e.stored_raw,
                  rsp_data.out_byte, rsp_data.out_last, rsp_data.stored_raw);
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int n, len, sel;
      logic [7:0] vals [5];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      mismatches = 0;
      items_sent = 0;
      quiet = 1'b0;
      clear_chunk();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty chunk, pull after end, accepted 8-byte chunk, one-byte chunks
      add_row(bde_pkg::KIND_PULL, 8'h00, 1'b0, 1, 1, 8'h00, 1, 1);
      add_row(bde_pkg::KIND_PULL, 8'hFF, 1'b1, 1, 0, 8'h00, 0, 0);
      for (int i = 0; i < 8; i++)
         add_row(bde_pkg::KIND_LOAD, 8'hA5, i == 7, 1, 0, 8'h00, 0, 0);
      add_row(bde_pkg::KIND_PULL, 8'h00, 1'b0, 1, 1, 8'h01, 0, 0);
      add_row(bde_pkg::KIND_PULL, 8'h00, 1'b0, 1, 1, 8'hA5, 0, 0);
      add_row(bde_pkg::KIND_PULL, 8'h00, 1'b0, 1, 1, 8'h00, 1, 0);
      add_row(bde_pkg::KIND_PULL, 8'h00, 1'b0, 1, 0, 8'h00, 0, 0);
      add_row(bde_pkg::KIND_LOAD, 8'h00, 1'b1, 1, 0, 8'h00, 0, 0);
      add_row(bde_pkg::KIND_PULL, 8'h00, 1'b0, 1, 1, 8'h00, 1, 1);
      add_row(bde_pkg::KIND_LOAD, 8'hFF, 1'b0, 1, 0, 8'h00, 0, 0);
      add_row(bde_pkg::KIND_PULL, 8'h00, 1'b0, 1, 1, 8'h00, 1, 1);
      add_row(bde_pkg::KIND_LOAD, 8'h3C, 1'b0, 0, 0, 8'h00, 0, 0);
      add_row(bde_pkg::KIND_LOAD, 8'hC3, 1'b1, 0, 0, 8'h00, 0, 0);
      add_row(bde_pkg::KIND_PULL, 8'h00, 1'b0, 0, 0, 8'h00, 0, 0);
      foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].has, rows[i].x);

      // 255th distinct value declines the chunk
      for (int i = 0; i < 256; i++) load(8'(i), i == 255);
      pull();
      pull();

      // sender holds off until every expected item is back
      hold_off();

      while (items_sent < 650) begin
         if (items_sent > 560) quiet = 1'b1;
         sel = $urandom_range(0, 9);
         if (sel <= 5) begin
            // chunk of few values (one to five), 16 to 90 bytes long
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) vals[i] = 8'($urandom);
            len = $urandom_range(16, 90);
            for (int i = 0; i < len; i++) load(vals[$urandom_range(0, n - 1)], i == len - 1);
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) pull();
            else while (phase != PH_DONE) pull();
            if ($urandom_range(0, 3) == 0) pull();
         end else if (sel <= 7) begin
            // noise: random bytes and marks, random pulls
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++) load(8'($urandom), $urandom_range(0, 19) == 0);
            repeat ($urandom_range(0, 6)) pull();
         end else begin
            // pull while loading closes the chunk early
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) vals[i] = 8'($urandom);
            len = $urandom_range(0, 60);
            for (int i = 0; i < len; i++) load(vals[$urandom_range(0, n - 1)], 1'b0);
            repeat ($urandom_range(1, 12)) pull();
         end
         if (!quiet && $urandom_range(0, 40) == 0) hold_off();
      end
      quiet = 1'b1;
      while (phase == PH_EMIT) pull();
      req_valid <= 1'b0;

      wait (expected_bytes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
